// ----- rtl/ed_erd_pkg.sv -----
// Package for the ED-escaped run-length decoder.
// Holds field widths, byte codes, parser phases, finish codes and the result type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ed_erd_pkg;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int OFFSET_W = 16;
  localparam int KIND_W   = 2;

  // Byte codes of the scheme.
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hED;
  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h00;

  // Output byte limit after reset.
  localparam logic [OFFSET_W-1:0] MAX_LENGTH_RESET = 16'd16384;

  // Finish codes carried by each result.
  localparam logic [KIND_W-1:0] FK_RUN  = 2'd0;
  localparam logic [KIND_W-1:0] FK_END  = 2'd1;
  localparam logic [KIND_W-1:0] FK_FULL = 2'd2;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_ESC2  = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
    logic [OFFSET_W-1:0] offset;
    logic [KIND_W-1:0]   kind;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ed_erd_if.sv -----
// Channel interfaces of the ED-escaped run-length decoder: input bytes,
// results and the configuration write channel. Depends on ed_erd_pkg.
`default_nettype none

// Compressed byte channel.
interface ed_erd_in_if;
  import ed_erd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              start_block;

  modport source (output valid, in_byte, start_block, input ready);
  modport sink   (input valid, in_byte, start_block, output ready);
endinterface

// Result channel.
interface ed_erd_out_if;
  import ed_erd_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_value;
  logic [COUNT_W-1:0]  out_count;
  logic [OFFSET_W-1:0] out_offset;
  logic [KIND_W-1:0]   finish_kind;
  logic                last;

  modport source (output valid, out_value, out_count, out_offset, finish_kind, last,
                  input ready);
  modport sink   (input valid, out_value, out_count, out_offset, finish_kind, last,
                  output ready);
endinterface

// Configuration write channel for max_length.
interface ed_erd_cfg_if;
  import ed_erd_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] max_length;

  modport source (output valid, max_length, input ready);
  modport sink   (input valid, max_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/ed_escape_rle_decoder.sv -----
// Top level of the ED-escaped run-length decoder: parser, block state and a
// four-entry result queue. Depends on ed_erd_pkg and the interfaces in ed_erd_if.sv.
`default_nettype none

// The decoder takes one compressed byte per cycle while the queue has room, giving
// zero, one or two result items (value, count, offset, finish kind, last). A run
// ED ED n v leaves as a single item with count n (256 for n = 0), capped at the
// room left below max_length; a lone ED before another byte gives two items, fewer
// at the limit. Each byte is decoded combinationally into a four-entry result
// queue, which accepts a byte whenever it has room for two items, so the sustained
// rate is one byte per cycle while results are taken as fast as they appear; two
// items of one byte leave one by one, as the output side sets the pace. start_block
// clears the block state before its byte is handled. The user must write max_length
// through the configuration channel only while idle; the block does not enforce it.

module ed_escape_rle_decoder (
  input  wire logic  clk,
  input  wire logic  rst,
  ed_erd_in_if.sink    in_stream,
  ed_erd_out_if.source out_stream,
  ed_erd_cfg_if.sink   cfg
);
  import ed_erd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration and block state.
  logic [OFFSET_W-1:0] max_length;
  phase_t              phase;
  logic [BYTE_W-1:0]   last_literal;
  logic [BYTE_W-1:0]   run_count;
  logic [OFFSET_W-1:0] out_position;
  logic                finished;

  phase_t              phase_next;
  logic [BYTE_W-1:0]   last_literal_next;
  logic [BYTE_W-1:0]   run_count_next;
  logic [OFFSET_W-1:0] out_position_next;
  logic                finished_next;

  // Results of the current byte.
  result_t     res0;
  result_t     res1;
  logic [1:0]  res_num;

  // Result queue.
  result_t           queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   q_count;

  logic in_acc;
  logic out_acc;

  // Effective state after an optional start_block clear.
  phase_t              ph_e;
  logic [BYTE_W-1:0]   ll_e;
  logic [BYTE_W-1:0]   rc_e;
  logic [OFFSET_W-1:0] pos_e;
  logic                fin_e;
  logic [OFFSET_W-1:0] room;
  logic [COUNT_W-1:0]  run_len;
  logic [COUNT_W-1:0]  run_n;
  logic [BYTE_W-1:0]   b;

  assign cfg.ready       = 1'b1;
  assign in_stream.ready = (q_count <= (QPTR_W+1)'(QDEPTH - 2));
  assign in_acc          = in_stream.valid && in_stream.ready;
  assign out_acc         = out_stream.valid && out_stream.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.max_length;
    end
  end

  // Byte decode: next state and up to two results.
  always_comb begin
    b     = in_stream.in_byte;
    ph_e  = in_stream.start_block ? PH_IDLE  : phase;
    ll_e  = in_stream.start_block ? ESC_BYTE : last_literal;
    rc_e  = in_stream.start_block ? '0       : run_count;
    pos_e = in_stream.start_block ? '0       : out_position;
    fin_e = in_stream.start_block ? 1'b0     : finished;
    room  = (max_length > pos_e) ? (max_length - pos_e) : '0;

    run_len = (rc_e == '0) ? COUNT_W'(256) : {1'b0, rc_e};
    run_n   = ({{(OFFSET_W-COUNT_W){1'b0}}, run_len} < room) ? run_len
                                                              : room[COUNT_W-1:0];

    phase_next        = ph_e;
    last_literal_next = ll_e;
    run_count_next    = rc_e;
    out_position_next = pos_e;
    finished_next     = fin_e;
    res_num           = 2'd0;
    res0              = '0;
    res1              = '0;
    res0.offset       = pos_e;

    if (!fin_e) begin
      case (ph_e)
        PH_ESC: begin
          if (b == ESC_BYTE) begin
            phase_next = PH_ESC2;
          end else begin
            phase_next        = PH_IDLE;
            last_literal_next = b;
            if (room == '0) begin
              res0.kind     = FK_FULL;
              finished_next = 1'b1;
              res_num       = 2'd1;
            end else if (room == OFFSET_W'(1)) begin
              res0          = '{ESC_BYTE, COUNT_W'(1), pos_e, FK_FULL, 1'b0};
              out_position_next = pos_e + OFFSET_W'(1);
              finished_next = 1'b1;
              res_num       = 2'd1;
            end else begin
              // Escape byte first, then the following byte.
              res0 = '{ESC_BYTE, COUNT_W'(1), pos_e, FK_RUN, 1'b0};
              res1 = '{b, COUNT_W'(1), pos_e + OFFSET_W'(1),
                       (room == OFFSET_W'(2)) ? FK_FULL : FK_RUN, 1'b0};
              out_position_next = pos_e + OFFSET_W'(2);
              finished_next     = (room == OFFSET_W'(2));
              res_num           = 2'd2;
            end
          end
        end
        PH_ESC2: begin
          if (ll_e == MARK_BYTE && b == MARK_BYTE) begin
            // End marker: 00 ED ED 00.
            phase_next    = PH_IDLE;
            finished_next = 1'b1;
            res0.kind     = FK_END;
            res_num       = 2'd1;
          end else begin
            run_count_next = b;
            phase_next     = PH_COUNT;
          end
        end
        PH_COUNT: begin
          phase_next = PH_IDLE;
          res_num    = 2'd1;
          if (room == '0) begin
            res0.kind     = FK_FULL;
            finished_next = 1'b1;
          end else begin
            res0.value        = b;
            res0.count        = run_n;
            out_position_next = pos_e + OFFSET_W'(run_n);
            if (OFFSET_W'(run_n) == room) begin
              res0.kind     = FK_FULL;
              finished_next = 1'b1;
            end
          end
        end
        default: begin
          if (b == ESC_BYTE) begin
            phase_next = PH_ESC;
          end else begin
            phase_next        = PH_IDLE;
            last_literal_next = b;
            res_num           = 2'd1;
            if (room == '0) begin
              res0.kind     = FK_FULL;
              finished_next = 1'b1;
            end else begin
              res0.value        = b;
              res0.count        = COUNT_W'(1);
              out_position_next = pos_e + OFFSET_W'(1);
              if (room == OFFSET_W'(1)) begin
                res0.kind     = FK_FULL;
                finished_next = 1'b1;
              end
            end
          end
        end
      endcase
    end

    res0.last = (res_num == 2'd1);
    res1.last = 1'b1;
  end

  // Block state register, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_literal <= ESC_BYTE;
      run_count    <= '0;
      out_position <= '0;
      finished     <= 1'b0;
    end else if (in_acc) begin
      phase        <= phase_next;
      last_literal <= last_literal_next;
      run_count    <= run_count_next;
      out_position <= out_position_next;
      finished     <= finished_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (res_num != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (res_num == 2'd2) begin
        queue[wr_ptr + QPTR_W'(1)] <= res1;
      end
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + QPTR_W'(res_num);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count + (in_acc ? (QPTR_W+1)'(res_num) : '0)
                         - (out_acc ? (QPTR_W+1)'(1) : '0);
    end
  end

  // Head of the queue drives the result channel.
  assign out_stream.valid       = (q_count != '0);
  assign out_stream.out_value   = queue[rd_ptr].value;
  assign out_stream.out_count   = queue[rd_ptr].count;
  assign out_stream.out_offset  = queue[rd_ptr].offset;
  assign out_stream.finish_kind = queue[rd_ptr].kind;
  assign out_stream.last        = queue[rd_ptr].last;

endmodule

`default_nettype wire

// ----- rtl/ed_erd_checker.sv -----
// Port-level checker for the ED-escaped run-length decoder, with the bind that
// attaches it to the top level. Depends on ed_erd_pkg.
`default_nettype none

module ed_erd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ed_erd_pkg::BYTE_W-1:0]   out_value,
  input wire logic [ed_erd_pkg::COUNT_W-1:0]  out_count,
  input wire logic [ed_erd_pkg::OFFSET_W-1:0] out_offset,
  input wire logic [ed_erd_pkg::KIND_W-1:0]   finish_kind,
  input wire logic                          last
);
  import ed_erd_pkg::*;

  // A stalled result holds its place and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_count)
      && $stable(out_offset) && $stable(finish_kind) && $stable(last))
    else $error("result changed while stalled");

  // The end marker gives a status-only item that closes its byte's results.
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && finish_kind == FK_END |-> out_count == '0 && out_value == '0 && last)
    else $error("end marker result malformed");

  // No results are pending in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // A result only appears after an accepted byte.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without an accepted item");

endmodule

bind ed_escape_rle_decoder ed_erd_checker u_ed_erd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_stream.valid),
  .in_ready    (in_stream.ready),
  .out_valid   (out_stream.valid),
  .out_ready   (out_stream.ready),
  .out_value   (out_stream.out_value),
  .out_count   (out_stream.out_count),
  .out_offset  (out_stream.out_offset),
  .finish_kind (out_stream.finish_kind),
  .last        (out_stream.last)
);

`default_nettype wire
